### hdl/dadm_pkg.sv
// ----------------------------------------------------------------------------
// dadm_pkg
// Shared types and constants of the truncating binary64 add/sub/mul/div unit.
// ----------------------------------------------------------------------------
package dadm_pkg;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_SUB = 2'd1,
    KIND_MUL = 2'd2,
    KIND_DIV = 2'd3
  } kind_e;

  localparam int unsigned FRAC_W = 52;
  localparam int unsigned EXP_W  = 11;
  localparam int unsigned SIG_W  = 53;
  localparam int unsigned WORD_W = 64;

  localparam logic [EXP_W-1:0] EXP_BIAS = 11'd1023;

  // quotient bits developed per divider stage
  localparam int unsigned DIV_ITER   = 54;
  localparam int unsigned DIV_STEP   = 2;
  localparam int unsigned DIV_STAGES = DIV_ITER / DIV_STEP;

  typedef struct packed {
    logic             sign;
    logic [EXP_W-1:0] expo;
    logic             off;
    logic [SIG_W:0]   quo;
  } div_res_t;

endpackage

### hdl/dadm_div.sv
// ----------------------------------------------------------------------------
// dadm_div
// Pipelined restoring divider for the significands: one setup stage, then
// two quotient bits per register stage.
// ----------------------------------------------------------------------------
module dadm_div import dadm_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [WORD_W-1:0] a_i,
  input  logic [WORD_W-1:0] b_i,
  output div_res_t          res_o
);

  logic [SIG_W:0]   rem_q  [0:DIV_STAGES];
  logic [SIG_W-1:0] dv_q   [0:DIV_STAGES];
  logic [SIG_W:0]   quo_q  [0:DIV_STAGES];
  logic             sign_q [0:DIV_STAGES];
  logic [EXP_W-1:0] expo_q [0:DIV_STAGES];
  logic             off_q  [0:DIV_STAGES];

  logic [SIG_W-1:0] ma, mb;
  logic             off_d;

  assign ma    = {1'b1, a_i[FRAC_W-1:0]};
  assign mb    = {1'b1, b_i[FRAC_W-1:0]};
  assign off_d = (mb > ma);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= {1'b0, ma};
      dv_q[0]   <= mb;
      quo_q[0]  <= '0;
      sign_q[0] <= a_i[WORD_W-1] ^ b_i[WORD_W-1];
      expo_q[0] <= a_i[WORD_W-2:FRAC_W] - b_i[WORD_W-2:FRAC_W] + EXP_BIAS
                   - {{(EXP_W-1){1'b0}}, off_d};
      off_q[0]  <= off_d;
    end
  end

  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_stage
    logic [SIG_W:0] rem_d;
    logic [SIG_W:0] quo_d;

    always_comb begin
      rem_d = rem_q[k-1];
      quo_d = quo_q[k-1];
      for (int j = 0; j < DIV_STEP; j++) begin
        if (rem_d >= {1'b0, dv_q[k-1]}) begin
          rem_d = rem_d - {1'b0, dv_q[k-1]};
          quo_d = {quo_d[SIG_W-1:0], 1'b1};
        end else begin
          quo_d = {quo_d[SIG_W-1:0], 1'b0};
        end
        // remainder stays below the divisor, so the shift cannot overflow
        rem_d = {rem_d[SIG_W-1:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        quo_q[k]  <= quo_d;
        dv_q[k]   <= dv_q[k-1];
        sign_q[k] <= sign_q[k-1];
        expo_q[k] <= expo_q[k-1];
        off_q[k]  <= off_q[k-1];
      end
    end
  end

  assign res_o.sign = sign_q[DIV_STAGES];
  assign res_o.expo = expo_q[DIV_STAGES];
  assign res_o.off  = off_q[DIV_STAGES];
  assign res_o.quo  = quo_q[DIV_STAGES];

endmodule

### hdl/double_add_sub_mul_div.sv
// ----------------------------------------------------------------------------
// double_add_sub_mul_div
// Truncating binary64 add, subtract, multiply and divide on raw bit patterns.
// ----------------------------------------------------------------------------
// Every operand is read as a normal number with a hidden one; results are
// truncated and the exponent wraps modulo 2048. The unit takes one operand
// pair per cycle while the output is not stalled and returns results in
// order. The divider is the deepest path, a restoring array that develops
// 54 quotient bits at two bits per stage; add and multiply finish after
// five stages and ride a delay line to the output.
// A stall on the output side freezes the whole pipeline without loss.
module double_add_sub_mul_div import dadm_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [127:0]  s_axis_tdata,  // a_bits [63:0], b_bits [127:64]
  input  logic [1:0]    s_axis_tuser,  // kind [1:0]
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [63:0]   m_axis_tdata,  // result_bits [63:0]
  output logic          m_axis_tuser   // zero_result [0]
);

  localparam int unsigned NSTG    = DIV_STAGES + 3;
  localparam int unsigned AM_LAST = 5;

  logic              adv;
  logic [NSTG:1]     valid_q;
  kind_e             kind_q [1:NSTG];
  logic [WORD_W-1:0] a1_q, b1_q;

  assign adv           = !valid_q[NSTG] || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (adv) begin
      valid_q <= {valid_q[NSTG-1:1], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      kind_q[1] <= kind_e'(s_axis_tuser);
      a1_q      <= s_axis_tdata[63:0];
      b1_q      <= s_axis_tdata[127:64];
      for (int s = 2; s <= NSTG; s++) kind_q[s] <= kind_q[s-1];
    end
  end

  // ---------------- add / subtract ----------------
  logic [WORD_W-1:0] b_eff, lead, other;
  logic [EXP_W-1:0]  ea, eb, shamt;
  logic [SIG_W-1:0]  om_full, om_sh;

  logic [SIG_W-1:0]  lm2_q, om2_q;
  logic              ls2_q, os2_q;
  logic [EXP_W-1:0]  el2_q;

  always_comb begin
    b_eff   = {b1_q[WORD_W-1] ^ (kind_q[1] == KIND_SUB), b1_q[WORD_W-2:0]};
    ea      = a1_q[WORD_W-2:FRAC_W];
    eb      = b_eff[WORD_W-2:FRAC_W];
    lead    = (ea >= eb) ? a1_q : b_eff;
    other   = (ea >= eb) ? b_eff : a1_q;
    shamt   = lead[WORD_W-2:FRAC_W] - other[WORD_W-2:FRAC_W];
    om_full = {1'b1, other[FRAC_W-1:0]};
    om_sh   = (shamt >= 11'd64) ? '0 : (om_full >> shamt);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lm2_q <= {1'b1, lead[FRAC_W-1:0]};
      om2_q <= om_sh;
      ls2_q <= lead[WORD_W-1];
      os2_q <= other[WORD_W-1];
      el2_q <= lead[WORD_W-2:FRAC_W];
    end
  end

  logic [SIG_W:0]   sum3_d, sum3_q;
  logic             sgn3_d, sgn3_q;
  logic [EXP_W-1:0] el3_q;

  always_comb begin
    if (ls2_q == os2_q) begin
      sum3_d = {1'b0, lm2_q} + {1'b0, om2_q};
      sgn3_d = ls2_q;
    end else if (lm2_q > om2_q) begin
      sum3_d = {1'b0, lm2_q - om2_q};
      sgn3_d = ls2_q;
    end else begin
      sum3_d = {1'b0, om2_q - lm2_q};
      sgn3_d = os2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sum3_q <= sum3_d;
      sgn3_q <= sgn3_d;
      el3_q  <= el2_q;
    end
  end

  // leading-one position of the sum
  logic [5:0]       top4_d, top4_q;
  logic             zero4_q;
  logic [SIG_W:0]   sum4_q;
  logic             sgn4_q;
  logic [EXP_W-1:0] el4_q;

  always_comb begin
    top4_d = '0;
    for (int i = 0; i <= SIG_W; i++) begin
      if (sum3_q[i]) top4_d = 6'(i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      top4_q  <= top4_d;
      zero4_q <= (sum3_q == '0);
      sum4_q  <= sum3_q;
      sgn4_q  <= sgn3_q;
      el4_q   <= el3_q;
    end
  end

  logic [SIG_W:0]    norm5;
  logic [EXP_W-1:0]  ae5;
  logic [WORD_W-1:0] add_res5;

  always_comb begin
    if (top4_q > 6'(FRAC_W)) begin
      norm5 = sum4_q >> 1;
    end else begin
      norm5 = sum4_q << (6'(FRAC_W) - top4_q);
    end
    ae5      = el4_q + {{(EXP_W-6){1'b0}}, top4_q} - EXP_W'(FRAC_W);
    add_res5 = zero4_q ? '0 : {sgn4_q, ae5, norm5[FRAC_W-1:0]};
  end

  // ---------------- multiply ----------------
  logic [SIG_W-1:0] mx, my;
  logic [63:0]      p00_q;
  logic [52:0]      p01_q, p10_q;
  logic [41:0]      p11_q;
  logic             ms2_q, ms3_q, ms4_q;
  logic [EXP_W-1:0] ee2_q, ee3_q, ee4_q;

  assign mx = {1'b1, a1_q[FRAC_W-1:0]};
  assign my = {1'b1, b1_q[FRAC_W-1:0]};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p00_q <= mx[31:0] * my[31:0];
      p01_q <= mx[31:0] * my[52:32];
      p10_q <= mx[52:32] * my[31:0];
      p11_q <= mx[52:32] * my[52:32];
      ms2_q <= a1_q[WORD_W-1] ^ b1_q[WORD_W-1];
      ee2_q <= a1_q[WORD_W-2:FRAC_W] + b1_q[WORD_W-2:FRAC_W];
    end
  end

  logic [63:0] p00_3q;
  logic [41:0] p11_3q;
  logic [53:0] mid3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p00_3q <= p00_q;
      p11_3q <= p11_q;
      mid3_q <= {1'b0, p01_q} + {1'b0, p10_q};
      ms3_q  <= ms2_q;
      ee3_q  <= ee2_q;
    end
  end

  logic [105:0] prod4_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod4_q <= {p11_3q, 64'd0} + {20'd0, mid3_q, 32'd0} + {42'd0, p00_3q};
      ms4_q   <= ms3_q;
      ee4_q   <= ee3_q;
    end
  end

  logic              moff5;
  logic [EXP_W-1:0]  me5;
  logic [WORD_W-1:0] mul_res5;

  always_comb begin
    moff5    = prod4_q[105];
    me5      = ee4_q + {{(EXP_W-1){1'b0}}, moff5} - EXP_BIAS;
    mul_res5 = {ms4_q, me5, moff5 ? prod4_q[104:53] : prod4_q[103:52]};
  end

  // ---------------- delay line for add and multiply results ----------------
  logic [WORD_W-1:0] res_q  [AM_LAST:NSTG-1];
  logic              zres_q [AM_LAST:NSTG-1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q[AM_LAST]  <= (kind_q[AM_LAST-1] == KIND_MUL) ? mul_res5 : add_res5;
      zres_q[AM_LAST] <= (kind_q[AM_LAST-1] == KIND_ADD ||
                          kind_q[AM_LAST-1] == KIND_SUB) && zero4_q;
      for (int s = AM_LAST + 1; s <= NSTG - 1; s++) begin
        res_q[s]  <= res_q[s-1];
        zres_q[s] <= zres_q[s-1];
      end
    end
  end

  // ---------------- divide ----------------
  div_res_t div_res;

  dadm_div u_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .a_i   (a1_q),
    .b_i   (b1_q),
    .res_o (div_res)
  );

  logic [SIG_W:0]    dquo;
  logic [WORD_W-1:0] out_res_q;
  logic              out_z_q;

  assign dquo = div_res.off ? div_res.quo : (div_res.quo >> 1);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (kind_q[NSTG-1] == KIND_DIV) begin
        out_res_q <= {div_res.sign, div_res.expo, dquo[FRAC_W-1:0]};
        out_z_q   <= 1'b0;
      end else begin
        out_res_q <= res_q[NSTG-1];
        out_z_q   <= zres_q[NSTG-1];
      end
    end
  end

  assign m_axis_tvalid = valid_q[NSTG];
  assign m_axis_tdata  = out_res_q;
  assign m_axis_tuser  = out_z_q;

  // ---------------- assertions ----------------
  a_no_flag_muldiv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (kind_q[NSTG] == KIND_MUL || kind_q[NSTG] == KIND_DIV)
    |-> !m_axis_tuser)
    else $error("zero flag raised on multiply or divide");

  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata == '0))
    else $error("cancellation flag with nonzero result");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(valid_q))
    else $error("pipeline moved during stall");

endmodule

### tb/double_add_sub_mul_div_tb.sv
// ----------------------------------------------------------------------------
// double_add_sub_mul_div_tb
// Self-checking bench for the truncating binary64 add/sub/mul/div unit.
// ----------------------------------------------------------------------------
// Operand pairs are streamed in with random gaps while the output side stalls
// at random. Every accepted pair is run through a local truncating float
// calculation; the expected words queue up and each output transfer is
// compared with the oldest one.
module double_add_sub_mul_div_tb import dadm_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] FRAC_MASK = 64'hF_FFFF_FFFF_FFFF;
  localparam logic [63:0] HIDDEN    = 64'h10_0000_0000_0000;
  localparam int unsigned LATENCY   = 30;
  localparam int unsigned MAX_CYC   = 400000;
  localparam int unsigned HOLD_CYC  = 200;

  typedef struct packed {
    logic [63:0] bits;
    logic        zero;
  } fp_res_t;

  function automatic logic [63:0] pack_fp(logic s, logic [10:0] e, logic [63:0] m);
    return {s, e, m[51:0]};
  endfunction

  function automatic fp_res_t fp_add(logic [63:0] a, logic [63:0] b);
    fp_res_t     r;
    logic [63:0] lead, other, lm, om, sum, shamt;
    logic        sgn;
    int          top;
    lead  = (a[62:52] >= b[62:52]) ? a : b;
    other = (a[62:52] >= b[62:52]) ? b : a;
    shamt = 64'(lead[62:52]) - 64'(other[62:52]);
    lm    = (lead & FRAC_MASK) | HIDDEN;
    om    = (other & FRAC_MASK) | HIDDEN;
    om    = (shamt >= 64) ? 64'd0 : (om >> shamt);
    if (lead[63] == other[63]) begin
      sum = lm + om; sgn = lead[63];
    end else if (lm > om) begin
      sum = lm - om; sgn = lead[63];
    end else begin
      sum = om - lm; sgn = other[63];
    end
    r.zero = (sum == 0);
    r.bits = 64'd0;
    if (sum != 0) begin
      top = 63;
      while (!sum[top]) top--;
      if (top > 52) sum = sum >> (top - 52);
      else sum = sum << (52 - top);
      r.bits = pack_fp(sgn, 11'(int'(lead[62:52]) + top - 52), sum);
    end
    return r;
  endfunction

  function automatic logic [63:0] fp_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    logic         off;
    p   = 128'((a & FRAC_MASK) | HIDDEN) * 128'((b & FRAC_MASK) | HIDDEN);
    off = p[105];
    p   = p >> (52 + off);
    return pack_fp(a[63] ^ b[63], 11'(a[62:52] + b[62:52] + off - 11'd1023), p[63:0]);
  endfunction

  function automatic logic [63:0] fp_div(logic [63:0] a, logic [63:0] b);
    logic [63:0] rem, dv, q;
    logic        off;
    rem = (a & FRAC_MASK) | HIDDEN;
    dv  = (b & FRAC_MASK) | HIDDEN;
    off = dv > rem;
    q   = 0;
    for (int i = 0; i < 54; i++) begin
      q = q << 1;
      if (rem >= dv) begin
        rem = rem - dv; q[0] = 1'b1;
      end
      rem = rem << 1;
    end
    if (!off) q = q >> 1;
    return pack_fp(a[63] ^ b[63], 11'(a[62:52] - b[62:52] + 11'd1023 - off), q);
  endfunction

  class fp_scoreboard;
    fp_res_t expected_q[$];
    int      errors;

    function void note_operands(kind_e k, logic [63:0] a, logic [63:0] b);
      fp_res_t r;
      case (k)
        KIND_ADD: r = fp_add(a, b);
        KIND_SUB: r = fp_add(a, {~b[63], b[62:0]});
        KIND_MUL: begin r.bits = fp_mul(a, b); r.zero = 1'b0; end
        default:  begin r.bits = fp_div(a, b); r.zero = 1'b0; end
      endcase
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [63:0] bits, logic zero);
      fp_res_t e;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h zero=%b", bits, zero);
        return;
      end
      e = expected_q.pop_front();
      if (e.bits !== bits || e.zero !== zero) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp %h zero=%b, got %h zero=%b", e.bits, e.zero, bits, zero);
      end
    endfunction
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;   // a_bits [63:0], b_bits [127:64]
  logic [1:0]   s_axis_tuser = '0;   // kind [1:0]
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;        // result_bits [63:0]
  logic         m_axis_tuser;        // zero_result [0]

  fp_scoreboard sb = new();
  int unsigned  cycles;
  bit           hold_sink;
  bit           long_gaps = 1'b1;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  double_add_sub_mul_div u_top (.*);

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYC) begin
      $display("double_add_sub_mul_div regression: fail");
      $finish;
    end
  end

  function automatic int unsigned gap_len();
    if (!long_gaps) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(5, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // note inputs and check outputs at each edge
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      sb.note_operands(kind_e'(s_axis_tuser), s_axis_tdata[63:0], s_axis_tdata[127:64]);
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser);
  end

  // output stall pattern; on request hold off in one long stretch set by HOLD_CYC
  initial begin
    int unsigned g;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_sink) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk_i);
        hold_sink = 1'b0;
      end else begin
        g = gap_len();
        if (g != 0) begin
          m_axis_tready <= 1'b0;
          repeat (g) @(posedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_op(kind_e k, logic [63:0] a, logic [63:0] b);
    int unsigned g;
    g = gap_len();
    if (g != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= k;
    s_axis_tdata  <= {b, a};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic go_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // mostly nearby exponents, so that add and sub actually combine operands
  function automatic logic [63:0] near_word(logic [63:0] a);
    logic [63:0] w;
    w = rand_word();
    if ($urandom_range(0, 3) != 0) w[62:52] = a[62:52] + 11'($urandom_range(0, 6)) - 11'd3;
    if ($urandom_range(0, 9) == 0) w[51:0] = a[51:0] ^ 52'(64'd1 << $urandom_range(0, 51));
    return w;
  endfunction

  initial begin
    logic [63:0] a, b;
    kind_e       k;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corners: cancellation, wide shift, extremes, every kind
    send_op(KIND_SUB, 64'h3FF0_0000_0000_0000, 64'h3FF0_0000_0000_0000);
    send_op(KIND_ADD, 64'h4000_0000_0000_0000, 64'hC000_0000_0000_0000);
    send_op(KIND_ADD, 64'h7FF0_0000_0000_0000, 64'h0000_0000_0000_0001);
    send_op(KIND_ADD, 64'h4400_0000_0000_0000, 64'h3FF0_0000_0000_0000);
    send_op(KIND_SUB, 64'h3FF0_0000_0000_0000, 64'h3FFF_FFFF_FFFF_FFFF);
    send_op(KIND_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_op(KIND_ADD, 64'h0, 64'h0);
    send_op(KIND_SUB, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
    send_op(KIND_MUL, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    send_op(KIND_MUL, 64'h0, 64'h0);
    send_op(KIND_MUL, 64'h3FF0_0000_0000_0000, 64'hBFF8_0000_0000_0000);
    send_op(KIND_DIV, 64'h3FF0_0000_0000_0000, 64'h3FFF_FFFF_FFFF_FFFF);
    send_op(KIND_DIV, 64'h3FFF_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0000);
    send_op(KIND_DIV, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_op(KIND_DIV, 64'h4008_0000_0000_0000, 64'h4008_0000_0000_0000);

    // pause until drained
    go_idle();

    // back up the output for a long stretch while input keeps coming
    hold_sink = 1'b1;
    long_gaps = 1'b0;
    for (int i = 0; i < 60; i++) begin
      a = rand_word();
      send_op(kind_e'($urandom_range(0, 3)), a, near_word(a));
    end
    long_gaps = 1'b1;

    for (int i = 0; i < 700; i++) begin
      k = kind_e'($urandom_range(0, 3));
      a = rand_word();
      b = near_word(a);
      if ($urandom_range(0, 24) == 0) b = {$urandom_range(0, 1) ? a[63] : ~a[63], a[62:0]};
      if ($urandom_range(0, 29) == 0) long_gaps = ~long_gaps;
      send_op(k, a, b);
    end
    long_gaps = 1'b1;

    go_idle();
    repeat (LATENCY + 10) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("double_add_sub_mul_div regression: pass");
    else
      $display("double_add_sub_mul_div regression: fail");
    $finish;
  end
endmodule

### files.f
hdl/dadm_pkg.sv
hdl/dadm_div.sv
hdl/double_add_sub_mul_div.sv
tb/double_add_sub_mul_div_tb.sv
